// File: rtl/lpxr_pkg.sv
`default_nettype none

package lpxr_pkg;

   localparam int HEADER_BYTES = 4;
   localparam int MAX_PAYLOAD = 32;
   localparam int LENGTH_INDEX = 3;
   localparam int FRAME_DEPTH = HEADER_BYTES + MAX_PAYLOAD + 1;

   localparam int BYTE_W = 8;
   localparam int ADDR_W = $clog2(FRAME_DEPTH);
   localparam int POS_W = 6;
   localparam int TOTAL_W = BYTE_W + 1;
   localparam int RSP_DATA_W = 16;

   typedef struct packed {
      logic valid;
      logic [ADDR_W-1:0] last_addr;
   } lpxr_start_type;

endpackage

`default_nettype wire

// File: rtl/lpxr_ram.sv
`default_nettype none

module lpxr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 37
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/lpxr_rx.sv
`default_nettype none

module lpxr_rx (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          accept,
   input  wire logic [lpxr_pkg::BYTE_W-1:0]   rx_byte,
   output logic                               wr_en,
   output logic      [lpxr_pkg::ADDR_W-1:0]   wr_addr,
   output logic      [lpxr_pkg::BYTE_W-1:0]   wr_data,
   output lpxr_pkg::lpxr_start_type           start
);

   logic [lpxr_pkg::ADDR_W-1:0]  count_ff, count_in;
   logic [lpxr_pkg::BYTE_W-1:0]  check_ff, check_in;
   logic [lpxr_pkg::BYTE_W-1:0]  length_ff, length_in;
   logic [lpxr_pkg::ADDR_W-1:0]  count_next;
   logic [lpxr_pkg::BYTE_W-1:0]  length_eff;
   logic [lpxr_pkg::TOTAL_W-1:0] total;
   logic                         at_length;
   logic                         too_long;
   logic                         frame_done;

   always_comb begin
      count_next = count_ff + lpxr_pkg::ADDR_W'(1);
      at_length  = (count_ff == lpxr_pkg::ADDR_W'(lpxr_pkg::LENGTH_INDEX));
      length_eff = at_length ? rx_byte : length_ff;
      too_long   = at_length && (rx_byte > lpxr_pkg::BYTE_W'(lpxr_pkg::MAX_PAYLOAD));
      total      = lpxr_pkg::TOTAL_W'(lpxr_pkg::HEADER_BYTES) +
                   lpxr_pkg::TOTAL_W'(length_eff) + lpxr_pkg::TOTAL_W'(1);
      frame_done = (count_next >= lpxr_pkg::ADDR_W'(lpxr_pkg::HEADER_BYTES)) &&
                   (lpxr_pkg::TOTAL_W'(count_next) == total);

      count_in  = count_ff;
      check_in  = check_ff;
      length_in = length_eff;
      start.valid     = 1'b0;
      start.last_addr = count_ff;

      if (accept) begin
         priority if (too_long || frame_done) begin
            count_in    = '0;
            check_in    = '0;
            start.valid = frame_done && !too_long && (rx_byte == check_ff);
         end else begin
            count_in = count_next;
            check_in = check_ff ^ rx_byte;
         end
      end else begin
         length_in = length_ff;
      end
   end

   assign wr_en   = accept;
   assign wr_addr = count_ff;
   assign wr_data = rx_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         check_ff  <= '0;
         length_ff <= '0;
      end else begin
         count_ff  <= count_in;
         check_ff  <= check_in;
         length_ff <= length_in;
      end
   end

   // the count never runs past the end of the store
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff < lpxr_pkg::ADDR_W'(lpxr_pkg::FRAME_DEPTH))
      else $error("frame count beyond store depth");

   a_start_restarts: assert property (@(posedge clock) disable iff (reset)
      start.valid |=> (count_ff == '0) && (check_ff == '0))
      else $error("receiver did not restart after a good frame");

   a_overlong_drop: assert property (@(posedge clock) disable iff (reset)
      (accept && too_long) |-> !start.valid)
      else $error("overlong frame started emission");

endmodule

`default_nettype wire

// File: rtl/lpxr_tx.sv
`default_nettype none

module lpxr_tx (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire lpxr_pkg::lpxr_start_type          start,
   output logic                                   rd_en,
   output logic      [lpxr_pkg::ADDR_W-1:0]       rd_addr,
   input  wire logic [lpxr_pkg::BYTE_W-1:0]       rd_data,
   output logic                                   busy,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic      [lpxr_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                                   rsp_tlast
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_LOAD = 2'd1;
   localparam logic [1:0] ST_SEND = 2'd2;

   logic [1:0]                   state_ff, state_in;
   logic [lpxr_pkg::ADDR_W-1:0]  ptr_ff, ptr_in;
   logic [lpxr_pkg::ADDR_W-1:0]  last_ff, last_in;
   logic [lpxr_pkg::BYTE_W-1:0]  data_ff, data_in;
   logic                         is_last;
   logic                         taken;

   always_comb begin
      is_last  = (ptr_ff == last_ff);
      taken    = (state_ff == ST_SEND) && rsp_tready;
      state_in = state_ff;
      ptr_in   = ptr_ff;
      last_in  = last_ff;
      data_in  = data_ff;
      rd_en    = 1'b0;
      rd_addr  = ptr_ff + lpxr_pkg::ADDR_W'(1);

      unique case (state_ff)
         ST_IDLE: begin
            if (start.valid) begin
               rd_en    = 1'b1;
               rd_addr  = '0;
               ptr_in   = '0;
               last_in  = start.last_addr;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            data_in  = rd_data;
            state_in = ST_SEND;
         end
         ST_SEND: begin
            if (taken) begin
               if (is_last) begin
                  state_in = ST_IDLE;
               end else begin
                  rd_en    = 1'b1;
                  ptr_in   = ptr_ff + lpxr_pkg::ADDR_W'(1);
                  state_in = ST_LOAD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      ptr_ff  <= ptr_in;
      last_ff <= last_in;
      data_ff <= data_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_SEND);
   assign rsp_tlast  = is_last;
   assign rsp_tdata  = {{(lpxr_pkg::RSP_DATA_W - lpxr_pkg::POS_W - lpxr_pkg::BYTE_W){1'b0}},
                        lpxr_pkg::POS_W'(ptr_ff), data_ff};

   a_start_when_idle: assert property (@(posedge clock) disable iff (reset)
      start.valid |-> (state_ff == ST_IDLE))
      else $error("frame start while emitting");

   a_ptr_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (ptr_ff <= last_ff))
      else $error("emit position past frame end");

   a_next_fetch: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !rsp_tlast) |=> ((state_ff == ST_LOAD)
      && (ptr_ff == $past(ptr_ff) + lpxr_pkg::ADDR_W'(1))))
      else $error("next frame byte not fetched");

endmodule

`default_nettype wire

// File: rtl/length_prefixed_xor_frame_receiver_unit.sv
`default_nettype none

// channel  dir  tdata fields (low bit up)                          tuser  tlast
// req      in   rx_byte[7:0]                                       -      -
// rsp      out  frame_byte[7:0], byte_position[13:8], zero[15:14]  -      frame_end
//
// a request byte is taken whenever req_tready is high, as it is while a frame is received
// a good frame is sent from the frame store with one ram read and one output
// load per byte; req_tready is low until the last byte is taken
// a stalled rsp holds its byte and position; the store read waits on rsp_tready
// reset clears the counters and returns the emitter to idle; frame store contents are not cleared

module length_prefixed_xor_frame_receiver_unit (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [lpxr_pkg::BYTE_W-1:0]         req_tdata,   // rx_byte
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic      [lpxr_pkg::RSP_DATA_W-1:0]     rsp_tdata,   // frame_byte, byte_position
   output logic                                     rsp_tlast    // frame_end
);

   logic                          accept;
   logic                          busy;
   logic                          wr_en;
   logic [lpxr_pkg::ADDR_W-1:0]   wr_addr;
   logic [lpxr_pkg::BYTE_W-1:0]   wr_data;
   logic                          rd_en;
   logic [lpxr_pkg::ADDR_W-1:0]   rd_addr;
   logic [lpxr_pkg::BYTE_W-1:0]   rd_data;
   lpxr_pkg::lpxr_start_type      start;

   assign req_tready = !busy;
   assign accept     = req_tvalid && req_tready;

   lpxr_rx u_rx (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .rx_byte (req_tdata),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .start   (start)
   );

   lpxr_ram #(
      .WIDTH (lpxr_pkg::BYTE_W),
      .DEPTH (lpxr_pkg::FRAME_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   lpxr_tx u_tx (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .busy       (busy),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

// File: tb/sv/length_prefixed_xor_frame_receiver_unit_tb.sv
`timescale 1ns / 100ps

module length_prefixed_xor_frame_receiver_unit_tb;

   localparam int IDLE_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 100;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [lpxr_pkg::BYTE_W-1:0] frame_byte;
      logic [lpxr_pkg::POS_W-1:0]  byte_position;
      logic                        frame_end;
   } frame_beat_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [lpxr_pkg::BYTE_W-1:0]     req_tdata = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [lpxr_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                            rsp_tlast;

   // frame tracker state
   int unsigned                 rx_count;
   logic [lpxr_pkg::BYTE_W-1:0] rx_check;
   logic [lpxr_pkg::BYTE_W-1:0] rx_length;
   logic [lpxr_pkg::BYTE_W-1:0] rx_store [lpxr_pkg::FRAME_DEPTH];
   frame_beat_type              pending_frame_beats [$];

   bit idling_on = 1'b1;
   int rsp_hold_cycles = 0;
   int item_count = 0;
   int error_count = 0;
   int idle_cycles = 0;

   length_prefixed_xor_frame_receiver_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic void note_error(input string msg);
      error_count++;
      if (error_count <= REPORT_LIMIT) begin
         $display("%0t: %s", $time, msg);
      end
   endfunction

   // stores one byte and queues the whole frame once a good checksum closes it
   function automatic void absorb_rx_byte(input logic [lpxr_pkg::BYTE_W-1:0] rx_byte);
      int unsigned pos;
      int unsigned total;
      frame_beat_type beat;
      pos = rx_count;
      if (pos >= lpxr_pkg::FRAME_DEPTH) begin
         pos = 0;
         rx_check = '0;
      end
      rx_store[pos] = rx_byte;
      rx_count = pos + 1;
      if (pos == lpxr_pkg::LENGTH_INDEX) begin
         rx_length = rx_byte;
         if (rx_byte > lpxr_pkg::MAX_PAYLOAD) begin
            rx_count = 0;
            rx_check = '0;
            return;
         end
      end
      if (rx_count >= lpxr_pkg::HEADER_BYTES) begin
         total = lpxr_pkg::HEADER_BYTES + rx_length + 1;
         if (rx_count == total) begin
            if (rx_byte == rx_check) begin
               for (int unsigned k = 0; k < total; k++) begin
                  beat.frame_byte = rx_store[k];
                  beat.byte_position = lpxr_pkg::POS_W'(k);
                  beat.frame_end = (k + 1 == total);
                  pending_frame_beats.push_back(beat);
               end
            end
            rx_count = 0;
            rx_check = '0;
            return;
         end
      end
      rx_check ^= rx_byte;
   endfunction

   task automatic push_rx_byte(input logic [lpxr_pkg::BYTE_W-1:0] rx_byte);
      if (idling_on && $urandom_range(0, 5) == 0) begin
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_tdata = rx_byte;
      req_tvalid = 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      absorb_rx_byte(rx_byte);
      item_count++;
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   // header bytes below the length byte come from head, lowest byte first
   task automatic send_frame(input logic [23:0] head, input int unsigned len,
                             input bit corrupt);
      logic [lpxr_pkg::BYTE_W-1:0] b;
      logic [lpxr_pkg::BYTE_W-1:0] sum;
      sum = '0;
      for (int i = 0; i < lpxr_pkg::HEADER_BYTES + len; i++) begin
         if (i == lpxr_pkg::LENGTH_INDEX) b = len[lpxr_pkg::BYTE_W-1:0];
         else if (i < lpxr_pkg::LENGTH_INDEX) b = head[8*i +: 8];
         else b = lpxr_pkg::BYTE_W'($urandom_range(0, 255));
         sum ^= b;
         push_rx_byte(b);
      end
      if (corrupt) sum ^= lpxr_pkg::BYTE_W'($urandom_range(1, 255));
      push_rx_byte(sum);
   endtask

   task automatic send_oversize(input logic [23:0] head,
                                input logic [lpxr_pkg::BYTE_W-1:0] len_byte);
      for (int i = 0; i < lpxr_pkg::LENGTH_INDEX; i++) push_rx_byte(head[8*i +: 8]);
      push_rx_byte(len_byte);
   endtask

   task automatic test_directed_frames();
      send_frame(24'h563412, 0, 1'b0);
      send_frame(24'h000000, 0, 1'b0);
      send_frame(24'hAA00FF, 1, 1'b0);
      send_frame(24'h0F0F0F, 0, 1'b1);
      send_oversize(24'h030201, lpxr_pkg::BYTE_W'(lpxr_pkg::MAX_PAYLOAD + 1));
      send_oversize(24'hFFFFFF, 8'hFF);
   endtask

   // long receiver hold while a full frame and the next one are offered
   task automatic test_output_stall();
      rsp_hold_cycles = LONG_HOLD_CYCLES;
      send_frame(24'($urandom), lpxr_pkg::MAX_PAYLOAD, 1'b0);
      send_frame(24'($urandom), 3, 1'b0);
   endtask

   task automatic test_drain_pause();
      while (pending_frame_beats.size() != 0) @(negedge clock);
      send_frame(24'($urandom), 0, 1'b0);
   endtask

   task automatic test_random_traffic(input int target);
      int pick;
      while (item_count < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            send_frame(24'($urandom), $urandom_range(0, lpxr_pkg::MAX_PAYLOAD), 1'b0);
         end else if (pick < 80) begin
            send_frame(24'($urandom), $urandom_range(0, lpxr_pkg::MAX_PAYLOAD), 1'b1);
         end else if (pick < 88) begin
            send_oversize(24'($urandom),
                          lpxr_pkg::BYTE_W'($urandom_range(lpxr_pkg::MAX_PAYLOAD + 1, 255)));
         end else begin
            repeat ($urandom_range(1, 10)) begin
               push_rx_byte(lpxr_pkg::BYTE_W'($urandom_range(0, 255)));
            end
            // resync to a frame boundary
            while (rx_count != 0) begin
               if (rx_count == lpxr_pkg::LENGTH_INDEX) begin
                  push_rx_byte(
                     lpxr_pkg::BYTE_W'($urandom_range(lpxr_pkg::MAX_PAYLOAD + 1, 255)));
               end else begin
                  push_rx_byte(lpxr_pkg::BYTE_W'($urandom_range(0, 255)));
               end
            end
         end
      end
   endtask

   task automatic test_quiet_tail(input int target);
      idling_on = 1'b0;
      while (item_count < target) begin
         send_frame(24'($urandom), $urandom_range(0, lpxr_pkg::MAX_PAYLOAD), 1'b0);
      end
   endtask

   initial begin : rsp_side
      int stall_left;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_hold_cycles--;
            rsp_tready = 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready = 1'b0;
         end else if (idling_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 5);
            rsp_tready = 1'b0;
         end else begin
            rsp_tready = 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      frame_beat_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_frame_beats.size() == 0) begin
            note_error($sformatf("unexpected frame byte: data %h last %b",
                                 rsp_tdata, rsp_tlast));
         end else begin
            want = pending_frame_beats.pop_front();
            if (rsp_tdata[lpxr_pkg::BYTE_W-1:0] !== want.frame_byte ||
                rsp_tdata[lpxr_pkg::BYTE_W +: lpxr_pkg::POS_W] !== want.byte_position ||
                rsp_tdata[lpxr_pkg::RSP_DATA_W-1:lpxr_pkg::BYTE_W+lpxr_pkg::POS_W] !== '0 ||
                rsp_tlast !== want.frame_end) begin
               note_error($sformatf(
                  "frame byte mismatch: expected byte %h pos %0d last %b, got data %h last %b",
                  want.frame_byte, want.byte_position, want.frame_end, rsp_tdata, rsp_tlast));
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("length_prefixed_xor_frame_receiver_unit regression: fail");
         $finish;
      end
   end

   initial begin
      rx_count = 0;
      rx_check = '0;
      rx_length = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_frames();
      test_output_stall();
      test_drain_pause();
      test_random_traffic(410);
      test_quiet_tail(470);

      while (pending_frame_beats.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (error_count == 0 && pending_frame_beats.size() == 0) begin
         $display("length_prefixed_xor_frame_receiver_unit regression: pass");
      end else begin
         $display("length_prefixed_xor_frame_receiver_unit regression: fail");
      end
      $finish;
   end

endmodule
